[rtl/pointer_event_queue_coalesce_defines.svh]
// Assertion macros used by the queue's RTL.
`ifndef POINTER_EVENT_QUEUE_COALESCE_DEFINES_SVH
`define POINTER_EVENT_QUEUE_COALESCE_DEFINES_SVH

// The condition must hold at every clock edge outside reset.
`define PEQC_ASSERT_ALWAYS(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PEQC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/peqc_pkg.sv]
package peqc_pkg;

    localparam int PADDR_W = 3;

    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] PH_NONE = 2'd0;
    localparam logic [1:0] PH_MOVE = 2'd2;

    localparam logic REG_ENABLED = 1'b0;

    typedef struct packed {
        logic        interrupted;
        logic        pressed;
        logic [1:0]  phase;
        logic [31:0] payload;
    } fields_t;

    localparam int FIELDS_W = $bits(fields_t);
    localparam int TIME_W   = 32;

    typedef enum logic {
        ST_IDLE,
        ST_RESP
    } state_t;

endpackage

[rtl/peqc_ram.sv]
module peqc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/pointer_event_queue_coalesce.sv]
// Pointer event queue with move coalescing. A push, a clear or an ignored op
// leaves busy low, and the next word may start in the following cycle. A pop
// moves to a response state, since the queue entries sit in a synchronous
// memory with a registered read: busy is high in the cycle after the pop is
// accepted, in which out_valid is high for one cycle with the returned event.
// The receiver cannot stall, so a result must be taken in the cycle it appears.
// No clearing pass runs after reset; the block accepts words at once.
`include "pointer_event_queue_coalesce_defines.svh"

module pointer_event_queue_coalesce #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [peqc_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   op,
    input  logic [1:0]                   phase,
    input  logic                         pressed,
    input  logic                         interrupted,
    input  logic [31:0]                  sample_time,
    input  logic [31:0]                  payload,
    input  logic [31:0]                  current_ms,
    output logic                         out_valid,
    output logic [1:0]                   out_phase,
    output logic                         out_pressed,
    output logic                         out_interrupted,
    output logic [31:0]                  out_time,
    output logic [31:0]                  out_payload,
    output logic                         from_queue
);

    import peqc_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    state_t             state_reg, state_next;
    logic               enabled_reg, enabled_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic               held_reg, held_next;
    logic               tail_move_reg, tail_move_next;
    logic               hit_reg, hit_next;
    logic [TIME_W-1:0]  now_reg, now_next;

    logic               accept;
    logic               cfg_write;
    logic               push_ok;
    logic               flush;
    logic               coalesce;
    logic [SUM_W-1:0]   sum_tail;
    logic [SUM_W-1:0]   sum_last;
    logic [IDX_W-1:0]   tail_slot;
    logic [IDX_W-1:0]   last_slot;

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [TIME_W-1:0]  wr_time;
    fields_t            wr_fields;
    logic               mem_re;
    logic [TIME_W-1:0]  rd_time;
    fields_t            rd_fields;

    peqc_ram #(
        .WIDTH (TIME_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_time_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (wr_time),
        .re    (mem_re),
        .raddr (rd_idx_reg),
        .rdata (rd_time)
    );

    peqc_ram #(
        .WIDTH (FIELDS_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fields_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (wr_fields),
        .re    (mem_re),
        .raddr (rd_idx_reg),
        .rdata (rd_fields)
    );

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_ENABLED) ? {31'd0, enabled_reg} : 32'd0;
    assign enabled_next = (cfg_write && paddr[2] == REG_ENABLED) ? pwdata[0] : enabled_reg;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    assign push_ok  = enabled_reg && !(phase == PH_NONE && !interrupted);
    assign flush    = push_ok && (interrupted || fill_reg >= CNT_W'(QUEUE_DEPTH));
    assign coalesce = push_ok && !flush && phase == PH_MOVE && fill_reg != '0
                      && tail_move_reg;

    assign sum_tail  = SUM_W'(rd_idx_reg) + SUM_W'(fill_reg);
    assign sum_last  = sum_tail - SUM_W'(1);
    assign tail_slot = (sum_tail >= SUM_W'(QUEUE_DEPTH))
                       ? IDX_W'(sum_tail - SUM_W'(QUEUE_DEPTH)) : IDX_W'(sum_tail);
    assign last_slot = (sum_last >= SUM_W'(QUEUE_DEPTH))
                       ? IDX_W'(sum_last - SUM_W'(QUEUE_DEPTH)) : IDX_W'(sum_last);

    always_comb
    begin
        state_next     = state_reg;
        rd_idx_next    = rd_idx_reg;
        fill_next      = fill_reg;
        held_next      = held_reg;
        tail_move_next = tail_move_reg;
        hit_next       = hit_reg;
        now_next       = now_reg;
        mem_we         = 1'b0;
        mem_waddr      = tail_slot;
        mem_re         = 1'b0;
        wr_time        = sample_time;
        wr_fields      = '{interrupted: interrupted, pressed: pressed,
                           phase: phase, payload: payload};

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        OP_PUSH:
                        begin
                            if (flush)
                            begin
                                mem_we         = 1'b1;
                                mem_waddr      = '0;
                                wr_time        = current_ms;
                                wr_fields      = '{interrupted: 1'b1, pressed: 1'b0,
                                                   phase: PH_NONE, payload: 32'd0};
                                rd_idx_next    = '0;
                                fill_next      = CNT_W'(1);
                                held_next      = 1'b0;
                                tail_move_next = 1'b0;
                            end
                            else if (coalesce)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = last_slot;
                            end
                            else if (push_ok)
                            begin
                                mem_we         = 1'b1;
                                fill_next      = fill_reg + CNT_W'(1);
                                tail_move_next = (phase == PH_MOVE);
                            end
                        end
                        OP_POP:
                        begin
                            state_next = ST_RESP;
                            now_next   = current_ms;
                            hit_next   = (fill_reg != '0);
                            if (fill_reg != '0)
                            begin
                                mem_re      = 1'b1;
                                fill_next   = fill_reg - CNT_W'(1);
                                rd_idx_next = (rd_idx_reg == IDX_W'(QUEUE_DEPTH - 1))
                                              ? '0 : rd_idx_reg + IDX_W'(1);
                            end
                        end
                        OP_CLEAR:
                        begin
                            rd_idx_next = '0;
                            fill_next   = '0;
                            held_next   = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RESP:
            begin
                state_next = ST_IDLE;
                if (hit_reg)
                begin
                    held_next = rd_fields.pressed;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            enabled_reg   <= 1'b0;
            rd_idx_reg    <= '0;
            fill_reg      <= '0;
            held_reg      <= 1'b0;
            tail_move_reg <= 1'b0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            enabled_reg   <= enabled_next;
            rd_idx_reg    <= rd_idx_next;
            fill_reg      <= fill_next;
            held_reg      <= held_next;
            tail_move_reg <= tail_move_next;
            hit_reg       <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg <= now_next;
    end

    assign out_valid       = (state_reg == ST_RESP);
    assign from_queue      = hit_reg;
    assign out_phase       = hit_reg ? rd_fields.phase : PH_NONE;
    assign out_pressed     = hit_reg ? rd_fields.pressed : held_reg;
    assign out_interrupted = hit_reg ? rd_fields.interrupted : 1'b0;
    assign out_time        = hit_reg ? rd_time : now_reg;
    assign out_payload     = hit_reg ? rd_fields.payload : 32'd0;

    `PEQC_ASSERT_ALWAYS(a_fill_bound, fill_reg <= CNT_W'(QUEUE_DEPTH), "fill count above depth")
    `PEQC_ASSERT_NEXT(a_pop_answers, accept && op == OP_POP, out_valid, "pop gave no result")
    `PEQC_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid, "result strobe held two cycles")
    `PEQC_ASSERT_NEXT(a_flush_marker, accept && op == OP_PUSH && enabled_reg && interrupted, fill_reg == CNT_W'(1) && !held_reg, "flush left wrong state")

endmodule

[tb/sv/pointer_event_queue_coalesce_tb.sv]
module pointer_event_queue_coalesce_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import peqc_pkg::*;

    localparam int QUEUE_DEPTH = 16;
    localparam int STALL_LIMIT = 2000;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [1:0] PH_DOWN   = 2'd1;
    localparam logic [1:0] PH_UP     = 2'd3;

    typedef struct {
        logic [1:0]  op;
        logic [1:0]  phase;
        logic        pressed;
        logic        interrupted;
        logic [31:0] sample_time;
        logic [31:0] payload;
        logic [31:0] current_ms;
    } cmd_word_t;

    typedef struct {
        logic [1:0]  phase;
        logic        pressed;
        logic        interrupted;
        logic [31:0] ev_time;
        logic [31:0] payload;
        logic        from_queue;
    } popped_event_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                start = 1'b0;
    logic                busy;
    logic [1:0]          op = OP_CLEAR;
    logic [1:0]          phase = PH_NONE;
    logic                pressed = 1'b0;
    logic                interrupted = 1'b0;
    logic [31:0]         sample_time = '0;
    logic [31:0]         payload = '0;
    logic [31:0]         current_ms = '0;
    logic                out_valid;
    logic [1:0]          out_phase;
    logic                out_pressed;
    logic                out_interrupted;
    logic [31:0]         out_time;
    logic [31:0]         out_payload;
    logic                from_queue;

    cmd_word_t           pending_words[$];
    popped_event_t       expected_events[$];
    cmd_word_t           cur_word;
    popped_event_t       oldest_event;
    int                  queued_count = 0;
    int                  accepted_count = 0;
    int                  gap_cycles = 0;
    int                  stall_cycles = 0;
    int                  errors = 0;
    bit                  idle_on = 1'b1;

    logic [31:0]         slot_time[QUEUE_DEPTH];
    fields_t             slot_fields[QUEUE_DEPTH];
    int                  head_slot = 0;
    int                  fill_count = 0;
    logic                held_pressed = 1'b0;
    logic                enabled_cfg = 1'b0;

    pointer_event_queue_coalesce #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .start(start),
        .busy(busy),
        .op(op),
        .phase(phase),
        .pressed(pressed),
        .interrupted(interrupted),
        .sample_time(sample_time),
        .payload(payload),
        .current_ms(current_ms),
        .out_valid(out_valid),
        .out_phase(out_phase),
        .out_pressed(out_pressed),
        .out_interrupted(out_interrupted),
        .out_time(out_time),
        .out_payload(out_payload),
        .from_queue(from_queue)
    );

    always
    begin
        #1;
        clk = 1'b1;
        #1;
        clk = 1'b0;
    end

    function automatic void store_event(input int slot, input cmd_word_t w);
        fields_t f;
        f.interrupted = w.interrupted;
        f.pressed = w.pressed;
        f.phase = w.phase;
        f.payload = w.payload;
        slot_time[slot] = w.sample_time;
        slot_fields[slot] = f;
    endfunction

    function automatic void advance_event_queue(input cmd_word_t w);
        int slot;
        fields_t f;
        popped_event_t ev;
        case (w.op)
            OP_PUSH:
            begin
                if (!enabled_cfg || (w.phase == PH_NONE && !w.interrupted))
                    return;
                if (w.interrupted || fill_count >= QUEUE_DEPTH)
                begin
                    f.interrupted = 1'b1;
                    f.pressed = 1'b0;
                    f.phase = PH_NONE;
                    f.payload = '0;
                    head_slot = 0;
                    fill_count = 1;
                    held_pressed = 1'b0;
                    slot_time[0] = w.current_ms;
                    slot_fields[0] = f;
                    return;
                end
                if (w.phase == PH_MOVE && fill_count > 0)
                begin
                    slot = (head_slot + fill_count - 1) % QUEUE_DEPTH;
                    if (slot_fields[slot].phase == PH_MOVE)
                    begin
                        store_event(slot, w);
                        return;
                    end
                end
                store_event((head_slot + fill_count) % QUEUE_DEPTH, w);
                fill_count++;
            end
            OP_POP:
            begin
                if (fill_count > 0)
                begin
                    f = slot_fields[head_slot];
                    ev.phase = f.phase;
                    ev.pressed = f.pressed;
                    ev.interrupted = f.interrupted;
                    ev.ev_time = slot_time[head_slot];
                    ev.payload = f.payload;
                    ev.from_queue = 1'b1;
                    held_pressed = f.pressed;
                    head_slot = (head_slot + 1) % QUEUE_DEPTH;
                    fill_count--;
                end
                else
                begin
                    ev.phase = PH_NONE;
                    ev.pressed = held_pressed;
                    ev.interrupted = 1'b0;
                    ev.ev_time = w.current_ms;
                    ev.payload = '0;
                    ev.from_queue = 1'b0;
                end
                expected_events.push_back(ev);
            end
            OP_CLEAR:
            begin
                head_slot = 0;
                fill_count = 0;
                held_pressed = 1'b0;
            end
            default:
            begin
            end
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                advance_event_queue(cur_word);
                accepted_count++;
            end
            if (!start || !busy)
            begin
                if (gap_cycles > 0)
                begin
                    gap_cycles--;
                    start <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    cur_word = pending_words.pop_front();
                    op <= cur_word.op;
                    phase <= cur_word.phase;
                    pressed <= cur_word.pressed;
                    interrupted <= cur_word.interrupted;
                    sample_time <= cur_word.sample_time;
                    payload <= cur_word.payload;
                    current_ms <= cur_word.current_ms;
                    start <= 1'b1;
                    if (idle_on && $urandom_range(0, 9) == 0)
                        gap_cycles = $urandom_range(1, 11);
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(input string name, input logic [31:0] expected_val,
                                        input logic [31:0] actual_val);
        if (actual_val !== expected_val)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, expected_val, actual_val);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid)
        begin
            if (expected_events.size() == 0)
            begin
                $error("result word with no pop pending");
                errors++;
            end
            else
            begin
                oldest_event = expected_events.pop_front();
                check_field("out_phase", 32'(oldest_event.phase), 32'(out_phase));
                check_field("out_pressed", 32'(oldest_event.pressed), 32'(out_pressed));
                check_field("out_interrupted", 32'(oldest_event.interrupted),
                            32'(out_interrupted));
                check_field("out_time", oldest_event.ev_time, out_time);
                check_field("out_payload", oldest_event.payload, out_payload);
                check_field("from_queue", 32'(oldest_event.from_queue), 32'(from_queue));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || out_valid)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    function automatic void add_word(input logic [1:0] w_op, input logic [1:0] w_phase,
                                     input logic w_pressed, input logic w_interrupted,
                                     input logic [31:0] w_time, input logic [31:0] w_payload,
                                     input logic [31:0] w_now);
        cmd_word_t w;
        w.op = w_op;
        w.phase = w_phase;
        w.pressed = w_pressed;
        w.interrupted = w_interrupted;
        w.sample_time = w_time;
        w.payload = w_payload;
        w.current_ms = w_now;
        pending_words.push_back(w);
        queued_count++;
    endfunction

    function automatic void add_pop();
        add_word(OP_POP, 2'($urandom), 1'($urandom), 1'($urandom), $urandom, $urandom,
                 $urandom);
    endfunction

    function automatic void add_noise();
        add_word(2'($urandom), 2'($urandom), 1'($urandom), $urandom_range(0, 5) == 0,
                 $urandom, $urandom, $urandom);
    endfunction

    function automatic void add_gesture(input int pop_pct);
        logic [31:0] t;
        int moves;
        t = $urandom;
        moves = $urandom_range(0, 10);
        add_word(OP_PUSH, PH_DOWN, 1'b1, 1'b0, t, $urandom, $urandom);
        repeat (moves)
        begin
            if ($urandom_range(0, 99) < pop_pct)
                add_pop();
            t += $urandom_range(1, 40);
            add_word(OP_PUSH, PH_MOVE, $urandom_range(0, 9) != 0, $urandom_range(0, 39) == 0,
                     t, $urandom, $urandom);
        end
        if ($urandom_range(0, 99) < pop_pct)
            add_pop();
        add_word(OP_PUSH, PH_UP, $urandom_range(0, 9) == 0, 1'b0, t + 1, $urandom, $urandom);
        repeat ($urandom_range(0, 3))
            add_pop();
    endfunction

    // Pushes with no moves so nothing coalesces, which lets the queue overflow.
    function automatic void add_fill_burst();
        repeat ($urandom_range(12, 20))
            add_word(OP_PUSH, ($urandom_range(0, 1) != 0) ? PH_DOWN : PH_UP, 1'($urandom),
                     1'b0, $urandom, $urandom, $urandom);
        repeat ($urandom_range(2, 18))
            add_pop();
    endfunction

    task automatic run_random(input int n_words);
        int target;
        int pick;
        target = queued_count + n_words;
        while (queued_count < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                add_gesture(30);
            else if (pick < 70)
                add_fill_burst();
            else
                repeat ($urandom_range(1, 4))
                    add_noise();
        end
    endtask

    task automatic wait_idle();
        while (accepted_count != queued_count || expected_events.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic write_enabled(input logic en);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(4 * int'(REG_ENABLED));
        pwdata <= {31'($urandom), en};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        enabled_cfg = en;
    endtask

    initial
    begin
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;

        // While disabled, pushes drop and pops return idle events.
        add_word(OP_PUSH, PH_DOWN, 1'b1, 1'b0, 32'h1, 32'h2, 32'h3);
        add_word(OP_POP, PH_NONE, 1'b0, 1'b0, '0, '0, 32'h0);
        add_word(OP_POP, PH_UP, 1'b1, 1'b1, '1, '1, 32'hFFFF_FFFF);
        add_word(OP_CLEAR, PH_NONE, 1'b0, 1'b0, '0, '0, '0);
        wait_idle();

        write_enabled(1'b1);
        add_word(OP_PUSH, PH_DOWN, 1'b1, 1'b0, 32'h0, 32'h0, 32'h10);
        add_word(OP_PUSH, PH_MOVE, 1'b1, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h11);
        add_word(OP_PUSH, PH_MOVE, 1'b1, 1'b0, 32'h5, 32'hA5A5_A5A5, 32'h12);
        add_word(OP_PUSH, PH_UP, 1'b0, 1'b0, 32'h6, 32'h5A5A_5A5A, 32'h13);
        add_word(OP_PUSH, PH_NONE, 1'b1, 1'b0, 32'h7, 32'h1234_5678, 32'h14);
        add_word(OP_PUSH, PH_MOVE, 1'b1, 1'b0, 32'h8, 32'h0F0F_0F0F, 32'h15);
        add_word(OP_UNUSED, PH_MOVE, 1'b1, 1'b1, '1, '1, '1);
        repeat (4)
            add_word(OP_POP, PH_NONE, 1'b0, 1'b0, '0, '0, 32'h20);
        add_word(OP_POP, PH_NONE, 1'b0, 1'b0, '0, '0, 32'hFFFF_FFFF);
        add_word(OP_PUSH, PH_DOWN, 1'b1, 1'b0, 32'h30, 32'h31, 32'h32);
        add_word(OP_PUSH, PH_NONE, 1'b0, 1'b1, 32'h40, 32'h41, 32'h1234_5678);
        add_word(OP_PUSH, PH_MOVE, 1'b1, 1'b0, 32'h50, 32'h51, 32'h52);
        repeat (3)
            add_word(OP_POP, PH_NONE, 1'b0, 1'b0, '0, '0, 32'h60);
        add_word(OP_PUSH, PH_DOWN, 1'b1, 1'b0, 32'h70, 32'h71, 32'h72);
        add_word(OP_CLEAR, PH_MOVE, 1'b1, 1'b1, '1, '1, '1);
        add_word(OP_POP, PH_NONE, 1'b0, 1'b0, '0, '0, 32'h0);
        add_word(OP_PUSH, PH_MOVE, 1'b1, 1'b1, '1, '1, '1);
        add_word(OP_POP, PH_NONE, 1'b0, 1'b0, '0, '0, 32'h80);
        wait_idle();

        run_random(330);
        wait_idle();

        write_enabled(1'b0);
        run_random(60);
        wait_idle();

        write_enabled(1'b1);
        run_random(330);
        wait_idle();

        idle_on = 1'b0;
        run_random(250);
        wait_idle();
        repeat (10)
            @(posedge clk);

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[pointer_event_queue_coalesce.f]
+incdir+rtl
rtl/peqc_pkg.sv
rtl/peqc_ram.sv
rtl/pointer_event_queue_coalesce.sv
tb/sv/pointer_event_queue_coalesce_tb.sv
